// ===== rtl/core/lpfd_pkg.sv =====
// Shared types and constants for the length-prefixed frame deframer.
// Holds the header layout, the result kind codes and the result record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpfd_pkg;

	localparam int HDR_BYTES = 16;
	localparam int ID_AT     = 4;
	localparam int LEN_AT    = 12;
	localparam int CNT_W     = $clog2(HDR_BYTES + 1);
	localparam int IDX_W     = $clog2(HDR_BYTES);

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_EMPTY   = 2'd1,
		KIND_BAD_MAGIC = 2'd2
	} kind_t;

	typedef struct packed {
		logic        vld;
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [63:0] frame_id;
		logic [31:0] frame_length;
		logic        frame_last;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/lpfd_core.sv =====
// Frame parsing logic: header collection, magic check, payload counting.
// Produces at most one result record per accepted byte, combinationally.
// Depends on lpfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpfd_core (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_we,
	input  wire  [31:0]           cfg_wdata,
	input  wire                   accept,
	input  wire  [7:0]            stream_byte,
	output lpfd_pkg::result_t     res
);
	import lpfd_pkg::*;

	logic [31:0]      magic_q;
	logic [7:0]       hdr_q [HDR_BYTES];
	logic [CNT_W-1:0] hdr_count_q;
	logic [63:0]      held_id_q;
	logic [31:0]      held_len_q;
	logic [31:0]      seen_q;
	logic             err_stop_q;

	logic             in_header;
	logic             hdr_done;
	logic [31:0]      hdr_magic;
	logic [63:0]      hdr_id;
	logic [31:0]      hdr_len;
	logic [31:0]      seen_next;
	logic             pay_last;
	logic [IDX_W-1:0] wr_idx;

	assign in_header = (hdr_count_q < CNT_W'(HDR_BYTES));
	assign hdr_done  = in_header && (hdr_count_q == CNT_W'(HDR_BYTES - 1));
	assign wr_idx    = hdr_count_q[IDX_W-1:0];
	assign hdr_magic = {hdr_q[3], hdr_q[2], hdr_q[1], hdr_q[0]};
	assign hdr_id    = {hdr_q[ID_AT+7], hdr_q[ID_AT+6], hdr_q[ID_AT+5], hdr_q[ID_AT+4],
			hdr_q[ID_AT+3], hdr_q[ID_AT+2], hdr_q[ID_AT+1], hdr_q[ID_AT]};
	// The final header byte arrives with the current transfer and is not yet stored.
	assign hdr_len   = {stream_byte, hdr_q[LEN_AT+2], hdr_q[LEN_AT+1], hdr_q[LEN_AT]};
	assign seen_next = seen_q + 32'd1;
	assign pay_last  = (seen_next == held_len_q);

	always_comb begin
		res              = '0;
		res.kind         = KIND_PAYLOAD;
		if (!err_stop_q) begin
			if (in_header) begin
				if (hdr_done) begin
					if (hdr_magic != magic_q) begin
						res.vld  = 1'b1;
						res.kind = KIND_BAD_MAGIC;
					end else if (hdr_len == 32'd0) begin
						res.vld        = 1'b1;
						res.kind       = KIND_EMPTY;
						res.frame_id   = hdr_id;
						res.frame_last = 1'b1;
					end
				end
			end else begin
				res.vld          = 1'b1;
				res.kind         = KIND_PAYLOAD;
				res.payload_byte = stream_byte;
				res.frame_id     = held_id_q;
				res.frame_length = held_len_q;
				res.frame_last   = pay_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !err_stop_q && in_header) begin
			hdr_q[wr_idx] <= stream_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q     <= '0;
			hdr_count_q <= '0;
			held_id_q   <= '0;
			held_len_q  <= '0;
			seen_q      <= '0;
			err_stop_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				magic_q <= cfg_wdata;
			end
			if (accept && !err_stop_q) begin
				if (in_header) begin
					if (hdr_done) begin
						if (hdr_magic != magic_q) begin
							err_stop_q <= 1'b1;
						end else begin
							held_id_q  <= hdr_id;
							held_len_q <= hdr_len;
							seen_q     <= '0;
							if (hdr_len == 32'd0) begin
								hdr_count_q <= '0;
							end else begin
								hdr_count_q <= hdr_count_q + CNT_W'(1);
							end
						end
					end else begin
						hdr_count_q <= hdr_count_q + CNT_W'(1);
					end
				end else begin
					seen_q <= seen_next;
					if (pay_last) begin
						hdr_count_q <= '0;
					end
				end
			end
		end
	end

	// Once stopped by a bad magic word, the block stays stopped until reset.
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_stop_q |=> err_stop_q)
		else $error("error stop cleared without reset");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_count_q <= CNT_W'(HDR_BYTES))
		else $error("header count beyond header size");

	a_err_sets_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res.vld && res.kind == KIND_BAD_MAGIC) |=> err_stop_q)
		else $error("bad magic result without error stop");

	a_payload_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!in_header |-> (seen_q < held_len_q))
		else $error("payload count reached declared length in payload phase");

endmodule

`default_nettype wire

// ===== rtl/core/lpfd_oreg.sv =====
// Result register between the parser and the output channel.
// Takes a new record whenever it is empty or its record is being transferred.
// Depends on lpfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpfd_oreg (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   load,
	input  lpfd_pkg::result_t     res,
	input  wire                   out_stall,
	output logic                  busy,
	output lpfd_pkg::result_t     res_s1
);
	import lpfd_pkg::*;

	logic    out_vld_s1;
	result_t data_s1;

	assign busy   = out_vld_s1 && out_stall;
	assign res_s1 = '{vld: out_vld_s1, kind: data_s1.kind,
			payload_byte: data_s1.payload_byte, frame_id: data_s1.frame_id,
			frame_length: data_s1.frame_length, frame_last: data_s1.frame_last};

	always_ff @(posedge clk) begin
		if (load && res.vld) begin
			data_s1 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s1 <= 1'b0;
		end else if (load) begin
			out_vld_s1 <= res.vld;
		end else if (!out_stall) begin
			out_vld_s1 <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/length_prefixed_frame_deframer_unit.sv =====
// Top level of the length-prefixed frame deframer.
// Instantiates lpfd_core and lpfd_oreg; depends on lpfd_pkg.
//
// Usage: raw stream bytes enter on the input channel (in_valid, in_stall,
// stream_byte), one byte per transfer. Each frame starts with a 16-byte
// little-endian header of magic word, 64-bit id and 32-bit payload length.
// Results leave on the output channel (out_valid, out_stall and the result
// fields): one per payload byte, one for a frame of zero length, or a single
// bad magic result after which all bytes are absorbed without result until
// reset. Header bytes other than the last one give no result.
// The expected magic word is written through cfg_we and cfg_wdata; the user
// must write it only while the block is idle; the block does not enforce it.
// A result is valid in the cycle after its input transfer. A byte is taken
// every cycle unless a result stalls; the single result register sets the rate.
// When the receiver stalls while a result is held, in_stall rises and the
// held result stays unchanged until it is transferred.
// Reset clears all counters, the error stop and the magic word to zero.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_frame_deframer_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [31:0] cfg_wdata,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  stream_byte,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [1:0]  result_kind,
	output logic [7:0]  payload_byte,
	output logic [63:0] frame_id,
	output logic [31:0] frame_length,
	output logic        frame_last
);
	import lpfd_pkg::*;

	logic    accept;
	logic    busy;
	result_t res;
	result_t res_s1;

	assign in_stall = busy;
	assign accept   = in_valid && !busy;

	lpfd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.accept      (accept),
		.stream_byte (stream_byte),
		.res         (res)
	);

	lpfd_oreg u_oreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.res       (res),
		.out_stall (out_stall),
		.busy      (busy),
		.res_s1    (res_s1)
	);

	assign out_valid    = res_s1.vld;
	assign result_kind  = res_s1.kind;
	assign payload_byte = res_s1.payload_byte;
	assign frame_id     = res_s1.frame_id;
	assign frame_length = res_s1.frame_length;
	assign frame_last   = res_s1.frame_last;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for length_prefixed_frame_deframer_unit. It drives framed byte
// streams with random gaps and stalls and checks every result against a scoreboard class.
// Depends on lpfd_pkg and the deframer RTL.

module tb;
	import lpfd_pkg::*;

	class frame_tracker;
		typedef struct {
			kind_t       kind;
			logic [7:0]  data;
			logic [63:0] id;
			logic [31:0] len;
			logic        last;
		} deframed_t;

		logic [31:0] magic;
		logic [7:0]  hdr [HDR_BYTES];
		int unsigned hdr_count;
		logic [63:0] held_id;
		logic [31:0] held_len;
		logic [31:0] seen;
		bit          stopped;
		deframed_t   due [$];
		int unsigned failures;

		function new();
			magic = '0;
			hdr_count = 0;
			held_id = '0;
			held_len = '0;
			seen = '0;
			stopped = 1'b0;
			failures = 0;
		endfunction

		function void add_due(kind_t kind, logic [7:0] data, logic [63:0] id,
			logic [31:0] len, logic last);
			deframed_t r;
			r.kind = kind;
			r.data = data;
			r.id = id;
			r.len = len;
			r.last = last;
			due.push_back(r);
		endfunction

		function void note_byte(logic [7:0] b);
			if (stopped)
				return;
			if (hdr_count < HDR_BYTES) begin
				hdr[hdr_count] = b;
				hdr_count++;
				if (hdr_count < HDR_BYTES)
					return;
				if ({hdr[3], hdr[2], hdr[1], hdr[0]} != magic) begin
					stopped = 1'b1;
					add_due(KIND_BAD_MAGIC, 8'h00, 64'h0, 32'h0, 1'b0);
					return;
				end
				for (int i = 0; i < 8; i++)
					held_id[8*i +: 8] = hdr[ID_AT + i];
				for (int i = 0; i < 4; i++)
					held_len[8*i +: 8] = hdr[LEN_AT + i];
				seen = '0;
				if (held_len == 0) begin
					hdr_count = 0;
					add_due(KIND_EMPTY, 8'h00, held_id, 32'h0, 1'b1);
				end
				return;
			end
			seen = seen + 1;
			if (seen >= held_len) begin
				hdr_count = 0;
				add_due(KIND_PAYLOAD, b, held_id, held_len, 1'b1);
			end else begin
				add_due(KIND_PAYLOAD, b, held_id, held_len, 1'b0);
			end
		endfunction

		function void check_result(logic [1:0] kind, logic [7:0] data, logic [63:0] id,
			logic [31:0] len, logic last);
			deframed_t r;
			if (due.size() == 0) begin
				$error("unexpected result: result_kind %0d, payload_byte %h", kind, data);
				failures++;
				return;
			end
			r = due.pop_front();
			if (kind != r.kind) begin
				$error("result_kind: expected %0d, got %0d", r.kind, kind);
				failures++;
			end
			if (data != r.data) begin
				$error("payload_byte: expected %h, got %h", r.data, data);
				failures++;
			end
			if (id != r.id) begin
				$error("frame_id: expected %h, got %h", r.id, id);
				failures++;
			end
			if (len != r.len) begin
				$error("frame_length: expected %h, got %h", r.len, len);
				failures++;
			end
			if (last != r.last) begin
				$error("frame_last: expected %b, got %b", r.last, last);
				failures++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  stream_byte;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  result_kind;
	logic [7:0]  payload_byte;
	logic [63:0] frame_id;
	logic [31:0] frame_length;
	logic        frame_last;

	frame_tracker tracker;
	logic [31:0]  cur_magic;
	int unsigned  bytes_sent;
	bit           in_calm;
	int unsigned  in_calm_left;

	length_prefixed_frame_deframer_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stream_byte(stream_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.payload_byte(payload_byte),
		.frame_id(frame_id),
		.frame_length(frame_length),
		.frame_last(frame_last)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		if (in_calm_left == 0) begin
			in_calm = ($urandom_range(0, 2) == 0);
			in_calm_left = $urandom_range(10, 40);
		end
		in_calm_left--;
		gap = in_calm ? 0 : $urandom_range(0, 7);
		repeat (gap) @(negedge clk) in_valid <= 1'b0;
		@(negedge clk);
		in_valid <= 1'b1;
		stream_byte <= b;
		do @(posedge clk); while (in_stall);
		tracker.note_byte(b);
		bytes_sent++;
	endtask

	task automatic send_header(input logic [31:0] m, input logic [63:0] id,
		input logic [31:0] len);
		for (int i = 0; i < 4; i++)
			send_byte(m[8*i +: 8]);
		for (int i = 0; i < 8; i++)
			send_byte(id[8*i +: 8]);
		for (int i = 0; i < 4; i++)
			send_byte(len[8*i +: 8]);
	endtask

	task automatic write_magic(input logic [31:0] m);
		@(negedge clk) in_valid <= 1'b0;
		while (tracker.due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk) cfg_we <= 1'b0;
		tracker.magic = m;
		cur_magic = m;
	endtask

	task automatic run_frames(input int unsigned budget);
		int unsigned start;
		int unsigned pick;
		int unsigned len;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 20)
				len = 0;
			else if (pick < 80)
				len = $urandom_range(1, 16);
			else if (pick < 95)
				len = $urandom_range(17, 64);
			else
				len = $urandom_range(65, 300);
			send_header(cur_magic, {$urandom, $urandom}, len);
			for (int i = 0; i < len; i++)
				send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// The receiver holds off for a random number of cycles, then waits for a transfer.
	initial begin
		int unsigned hold;
		int unsigned calm_left;
		bit calm;
		out_stall = 1'b0;
		calm_left = 0;
		calm = 1'b0;
		forever begin
			if (calm_left == 0) begin
				calm = ($urandom_range(0, 2) == 0);
				calm_left = $urandom_range(10, 40);
			end
			calm_left--;
			hold = calm ? 0 : $urandom_range(0, 7);
			repeat (hold) @(negedge clk) out_stall <= 1'b1;
			@(negedge clk) out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_result(result_kind, payload_byte, frame_id, frame_length,
				frame_last);
	end

	initial begin
		tracker = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		stream_byte = '0;
		cur_magic = '0;
		bytes_sent = 0;
		in_calm = 1'b0;
		in_calm_left = 0;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// The magic word is still at its reset value for the first frames.
		send_header(cur_magic, 64'h0, 32'h0);
		send_header(cur_magic, '1, 32'h1);
		send_byte(8'hFF);
		send_header(cur_magic, {$urandom, $urandom}, 32'h2);
		send_byte(8'h00);
		send_byte(8'hFF);

		write_magic(32'hFFFF_FFFF);
		send_header(cur_magic, {$urandom, $urandom}, 32'h0);
		send_header(cur_magic, {$urandom, $urandom}, 32'h3);
		send_byte(8'h80);
		send_byte(8'h7F);
		send_byte(8'h01);
		run_frames(375);

		write_magic($urandom);
		run_frames(375);
		write_magic(32'h0);
		run_frames(375);
		write_magic($urandom);
		run_frames(375);

		// A header whose magic word is off by one bit stops the block for good.
		send_header(cur_magic ^ (32'h1 << $urandom_range(0, 31)), {$urandom, $urandom},
			$urandom_range(0, 16));
		repeat (12) send_byte(8'($urandom_range(0, 255)));
		@(negedge clk) in_valid <= 1'b0;

		while (tracker.due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (tracker.failures == 0) begin
			$display("[length_prefixed_frame_deframer_unit] OK");
		end else begin
			$display("[length_prefixed_frame_deframer_unit] ERROR");
		end
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("[length_prefixed_frame_deframer_unit] ERROR");
		$finish;
	end
endmodule
